### rtl/core/ctl_pkg.sv
package ctl_pkg;

    // Fixed field widths of the command and result ports
    localparam int CITY_W = 8;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 35;

    // Saturation ceiling of the running tour length
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_VISIT = 1'b1;

endpackage

### rtl/core/ctl_root.sv
module ctl_root #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2*COORD_BITS:0]         sq,
    output logic                          done,
    output logic [COORD_BITS+FRAC_BITS:0] root
);

    localparam int RW    = COORD_BITS + FRAC_BITS + 1;
    localparam int RAD_W = 2 * RW;
    localparam int CW    = $clog2(RW);

    logic [RAD_W-1:0] rad_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CW-1:0]    count_reg;
    logic             run_reg;
    logic             done_reg;

    logic [RW+1:0]    rem_shift;
    logic [RW+1:0]    trial;
    logic             fits;

    // Bring in the next radicand pair and try the next root bit
    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    // One root bit per cycle, restoring form
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            count_reg <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg   <= RAD_W'(sq) << (2 * FRAC_BITS);
                rem_reg   <= '0;
                root_reg  <= '0;
                count_reg <= '0;
                run_reg   <= 1'b1;
            end
            else if (run_reg)
            begin
                rad_reg <= rad_reg << 2;
                // Remainder stays below 2^RW on every step that reads it back
                if (fits)
                begin
                    rem_reg  <= RW'(rem_shift - trial);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= RW'(rem_shift);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                if (count_reg == CW'(RW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/core/closed_tour_length.sv
// Load command: accepted while idle, busy stays low.
// First visit of a tour: busy through the city table read.
// Later visit: busy through states ST_READ, ST_DIFF, ST_SQ, ST_SUM and ST_ROOT,
// the last waiting on the bit-serial square root (one root bit per cycle).
// Last visit adds the closing leg: a second pass from ST_DIFF to ST_ROOT.
// valid pulses once as busy drops; the receiver cannot stall. Reset clears the tour.
module closed_tour_length #(
    parameter int MAX_CITIES = 256,
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [ctl_pkg::CITY_W-1:0]  city,
    input  logic [ctl_pkg::POS_W-1:0]   xpos,
    input  logic [ctl_pkg::POS_W-1:0]   ypos,
    input  logic                        last,
    output logic                        valid,
    output logic [ctl_pkg::LEN_W-1:0]   tour_length
);

    import ctl_pkg::*;

    localparam int AW   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int CB   = COORD_BITS;
    localparam int SQ_W = 2 * CB + 1;
    localparam int RW   = CB + FRAC_BITS + 1;
    localparam int EW   = ((RW > LEN_W) ? RW : LEN_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQ,
        ST_SUM,
        ST_ROOT
    } state_t;

    state_t             state_reg;
    logic [CB-1:0]      x_mem [MAX_CITIES];
    logic [CB-1:0]      y_mem [MAX_CITIES];
    logic [CB-1:0]      x_rd_reg, y_rd_reg;
    logic [CB-1:0]      first_x_reg, first_y_reg;
    logic [CB-1:0]      prev_x_reg, prev_y_reg;
    logic [CB-1:0]      cur_x_reg, cur_y_reg;
    logic [CB-1:0]      ax_reg, ay_reg, bx_reg, by_reg;
    logic [CB-1:0]      dx_reg, dy_reg;
    logic [2*CB-1:0]    sqx_reg, sqy_reg;
    logic [LEN_W-1:0]   sum_reg;
    logic [LEN_W-1:0]   tour_length_reg;
    logic               in_tour_reg;
    logic               last_reg;
    logic               hit_reg;
    logic               closing_reg;
    logic               valid_reg;

    logic               accept;
    logic               in_range;
    logic [AW-1:0]      addr;
    logic [CB-1:0]      cx, cy;
    logic               root_start;
    logic [SQ_W-1:0]    sq;
    logic               root_done;
    logic [RW-1:0]      root;
    logic [EW-1:0]      total;
    logic [LEN_W-1:0]   sum_sat;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(city) < MAX_CITIES);
    assign addr     = AW'(city);

    // City tables: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && (command == CMD_LOAD) && in_range)
        begin
            x_mem[addr] <= CB'(xpos);
            y_mem[addr] <= CB'(ypos);
        end
        x_rd_reg <= x_mem[addr];
        y_rd_reg <= y_mem[addr];
    end

    // Out-of-range city reads as the origin
    assign cx = hit_reg ? x_rd_reg : '0;
    assign cy = hit_reg ? y_rd_reg : '0;

    // Squared leg length feeds the root unit
    assign root_start = (state_reg == ST_SUM);
    assign sq         = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    ctl_root #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .sq    (sq),
        .done  (root_done),
        .root  (root)
    );

    // Add the leg and clamp at full scale
    assign total   = EW'(sum_reg) + EW'(root);
    assign sum_sat = (total > EW'(LEN_MAX)) ? LEN_MAX : LEN_W'(total);

    // Tour sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            bx_reg          <= '0;
            by_reg          <= '0;
            dx_reg          <= '0;
            dy_reg          <= '0;
            sqx_reg         <= '0;
            sqy_reg         <= '0;
            sum_reg         <= '0;
            tour_length_reg <= '0;
            in_tour_reg     <= 1'b0;
            last_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            closing_reg     <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start && (command == CMD_VISIT))
                    begin
                        last_reg  <= last;
                        hit_reg   <= in_range;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    prev_x_reg <= cx;
                    prev_y_reg <= cy;
                    if (!in_tour_reg)
                    begin
                        // Open a tour; a lone city closes at once with zero
                        first_x_reg <= cx;
                        first_y_reg <= cy;
                        sum_reg     <= '0;
                        if (last_reg)
                        begin
                            valid_reg       <= 1'b1;
                            tour_length_reg <= '0;
                        end
                        else
                        begin
                            in_tour_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        ax_reg      <= prev_x_reg;
                        ay_reg      <= prev_y_reg;
                        bx_reg      <= cx;
                        by_reg      <= cy;
                        cur_x_reg   <= cx;
                        cur_y_reg   <= cy;
                        closing_reg <= 1'b0;
                        state_reg   <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    dx_reg    <= (ax_reg >= bx_reg) ? ax_reg - bx_reg : bx_reg - ax_reg;
                    dy_reg    <= (ay_reg >= by_reg) ? ay_reg - by_reg : by_reg - ay_reg;
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    sqx_reg   <= dx_reg * dx_reg;
                    sqy_reg   <= dy_reg * dy_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        if (closing_reg)
                        begin
                            // Closing leg done: transfer the total and rearm
                            valid_reg       <= 1'b1;
                            tour_length_reg <= sum_sat;
                            sum_reg         <= '0;
                            in_tour_reg     <= 1'b0;
                            state_reg       <= ST_IDLE;
                        end
                        else if (last_reg)
                        begin
                            // Queue the leg back to the first city
                            sum_reg     <= sum_sat;
                            ax_reg      <= cur_x_reg;
                            ay_reg      <= cur_y_reg;
                            bx_reg      <= first_x_reg;
                            by_reg      <= first_y_reg;
                            closing_reg <= 1'b1;
                            state_reg   <= ST_DIFF;
                        end
                        else
                        begin
                            sum_reg   <= sum_sat;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign valid       = valid_reg;
    assign tour_length = tour_length_reg;

`ifndef ASSERT_OFF
    // Results never come back to back
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe held for two cycles");

    // A visit always occupies the block
    a_visit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_VISIT)) |=> busy)
        else $error("visit accepted without going busy");

    // Outside a tour the running sum stays cleared
    a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_tour_reg |-> (sum_reg == '0))
        else $error("running sum not cleared outside a tour");

    // Root results arrive only while waiting for them
    a_root_owner: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == ST_ROOT))
        else $error("root finished outside the root wait state");
`endif

endmodule

### bench/tb.sv
module tb;
    import ctl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int SAT_VISITS     = 380;

    typedef struct {
        logic              command;
        logic [CITY_W-1:0] city;
        logic [POS_W-1:0]  xpos;
        logic [POS_W-1:0]  ypos;
        logic              last;
    } xfer_t;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic              command = CMD_LOAD;
    logic [CITY_W-1:0] city    = '0;
    logic [POS_W-1:0]  xpos    = '0;
    logic [POS_W-1:0]  ypos    = '0;
    logic              last    = 1'b0;
    logic              busy;
    logic              valid;
    logic [LEN_W-1:0]  tour_length;

    // Stimulus and scoreboard storage
    xfer_t             pending_xfers[$];
    logic [LEN_W-1:0]  expected_len[$];
    bit                loaded[256];
    logic              taken       = 1'b0;
    int                idle_pct    = 0;
    int                idle_cycles = 0;
    int                errors      = 0;
    int                n_xfers     = 0;
    int                n_tours     = 0;
    int                n_saturated = 0;

    // Predictor state: city tables and the tour in progress
    logic [POS_W-1:0]  tab_x[256];
    logic [POS_W-1:0]  tab_y[256];
    logic [POS_W-1:0]  start_x  = '0;
    logic [POS_W-1:0]  start_y  = '0;
    logic [POS_W-1:0]  last_x   = '0;
    logic [POS_W-1:0]  last_y   = '0;
    logic [LEN_W-1:0]  run_len  = '0;
    logic              touring  = 1'b0;

    closed_tour_length dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .city        (city),
        .xpos        (xpos),
        .ypos        (ypos),
        .last        (last),
        .valid       (valid),
        .tour_length (tour_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Leg length: floor(sqrt(dx^2 + dy^2) * 2^16), digit-by-digit integer root
    function automatic logic [26:0] leg_length(input logic [POS_W-1:0] ax,
                                               input logic [POS_W-1:0] ay,
                                               input logic [POS_W-1:0] bx,
                                               input logic [POS_W-1:0] by);
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        logic [63:0]      rad;
        logic [63:0]      res;
        logic [63:0]      one;
        dx  = (ax >= bx) ? ax - bx : bx - ax;
        dy  = (ay >= by) ? ay - by : by - ay;
        rad = (64'(dx) * 64'(dx) + 64'(dy) * 64'(dy)) << 32;
        res = '0;
        one = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rad >= res + one)
            begin
                rad = rad - (res + one);
                res = (res >> 1) + one;
            end
            else
            begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res[26:0];
    endfunction

    // Add a leg, clamp at the ceiling
    function automatic logic [LEN_W-1:0] add_clamped(input logic [LEN_W-1:0] acc,
                                                     input logic [26:0] d);
        logic [LEN_W:0] s;
        s = {1'b0, acc} + (LEN_W+1)'(d);
        return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    // Update tables or tour state for one accepted transfer
    task automatic predict_transfer(input xfer_t t);
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        if (t.command == CMD_LOAD)
        begin
            tab_x[t.city] = t.xpos;
            tab_y[t.city] = t.ypos;
        end
        else
        begin
            cx = tab_x[t.city];
            cy = tab_y[t.city];
            if (!touring)
            begin
                start_x = cx;
                start_y = cy;
                run_len = '0;
                touring = 1'b1;
            end
            else
            begin
                run_len = add_clamped(run_len, leg_length(last_x, last_y, cx, cy));
            end
            last_x = cx;
            last_y = cy;
            if (t.last)
            begin
                run_len = add_clamped(run_len, leg_length(cx, cy, start_x, start_y));
                expected_len.push_back(run_len);
                run_len = '0;
                touring = 1'b0;
            end
        end
    endtask

    task automatic report_fail(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    // Driver: hold an unaccepted transfer, otherwise pop the next or idle
    always @(negedge clk)
    begin : drive
        xfer_t nx;
        if (!start || taken)
        begin
            if (pending_xfers.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nx = pending_xfers.pop_front();
                start   <= 1'b1;
                command <= nx.command;
                city    <= nx.city;
                xpos    <= nx.xpos;
                ypos    <= nx.ypos;
                last    <= nx.last;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check results, predict accepted transfers, run the watchdog
    always @(posedge clk)
    begin : watch
        logic [LEN_W-1:0] want;
        xfer_t            cur;
        logic             accepted;
        accepted = rst_n && start && (busy === 1'b0);
        taken   <= accepted;
        if (rst_n)
        begin
            if (valid === 1'b1)
            begin
                n_tours++;
                if (expected_len.size() == 0)
                begin
                    report_fail($sformatf("unexpected result tour_length=%0h", tour_length));
                end
                else
                begin
                    want = expected_len.pop_front();
                    if (want == LEN_MAX)
                        n_saturated++;
                    if (tour_length !== want)
                        report_fail($sformatf("tour_length mismatch: expected %0h, got %0h",
                                              want, tour_length));
                end
            end
            if (accepted)
            begin
                cur.command = command;
                cur.city    = city;
                cur.xpos    = xpos;
                cur.ypos    = ypos;
                cur.last    = last;
                predict_transfer(cur);
                n_xfers++;
            end
            if (accepted || valid === 1'b1)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no transfer and no result for %0d cycles",
                             WATCHDOG_LIMIT);
                    $display("tb NOT OK");
                    $finish;
                end
            end
        end
    end

    // Stimulus helpers
    task automatic queue_xfer(input logic cmd, input logic [CITY_W-1:0] c,
                              input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic lst);
        xfer_t t;
        t.command = cmd;
        t.city    = c;
        t.xpos    = x;
        t.ypos    = y;
        t.last    = lst;
        if (cmd == CMD_LOAD)
            loaded[c] = 1'b1;
        pending_xfers.push_back(t);
    endtask

    // Visits carry junk coordinates, which the block must ignore
    task automatic queue_visit(input logic [CITY_W-1:0] c, input logic lst);
        queue_xfer(CMD_VISIT, c, POS_W'($urandom_range(1023)), POS_W'($urandom_range(1023)),
                   lst);
    endtask

    function automatic logic [POS_W-1:0] rand_coord();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return POS_W'($urandom_range(1023));
        endcase
    endfunction

    // Pick a city that has been loaded, so no visit reads an unwritten entry
    function automatic logic [CITY_W-1:0] pick_loaded();
        logic [CITY_W-1:0] c;
        c = CITY_W'($urandom_range(255));
        while (!loaded[c])
            c = CITY_W'($urandom_range(255));
        return c;
    endfunction

    // Random traffic: load bursts and tours, loads sprinkled into tours
    task automatic gen_traffic(input int n);
        int made;
        int kind;
        int cnt;
        made = 0;
        while (made < n)
        begin
            kind = $urandom_range(99);
            if (kind < 20)
            begin
                cnt = $urandom_range(1, 6);
                for (int i = 0; i < cnt; i++)
                    queue_xfer(CMD_LOAD, CITY_W'($urandom_range(255)), rand_coord(),
                               rand_coord(), 1'($urandom_range(1)));
                made += cnt;
            end
            else
            begin
                cnt = (kind < 90) ? $urandom_range(1, 10) : $urandom_range(11, 40);
                for (int v = 0; v < cnt; v++)
                begin
                    if ($urandom_range(99) < 8)
                    begin
                        queue_xfer(CMD_LOAD, CITY_W'($urandom_range(255)), rand_coord(),
                                   rand_coord(), 1'($urandom_range(1)));
                        made++;
                    end
                    queue_visit(pick_loaded(), v == cnt - 1);
                    made++;
                end
            end
        end
    endtask

    task automatic wait_sent();
        while (pending_xfers.size() != 0 || start)
            @(posedge clk);
    endtask

    initial
    begin : stim
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: corners, single-city tour, zero leg, loads during a tour
        idle_pct = 11;
        queue_xfer(CMD_LOAD, 8'd0, '0, '0, 1'b1);
        queue_xfer(CMD_LOAD, 8'd255, '1, '1, 1'b0);
        queue_xfer(CMD_LOAD, 8'd1, '1, '0, 1'b0);
        queue_xfer(CMD_LOAD, 8'd2, '0, '1, 1'b1);
        queue_visit(8'd0, 1'b1);
        queue_visit(8'd0, 1'b0);
        queue_visit(8'd255, 1'b1);
        queue_visit(8'd1, 1'b0);
        queue_visit(8'd255, 1'b0);
        queue_visit(8'd2, 1'b0);
        queue_visit(8'd0, 1'b1);
        queue_visit(8'd255, 1'b0);
        queue_visit(8'd255, 1'b1);
        queue_visit(8'd1, 1'b0);
        queue_xfer(CMD_LOAD, 8'd1, 10'd5, 10'd7, 1'b1);
        queue_visit(8'd2, 1'b0);
        queue_xfer(CMD_LOAD, 8'd2, 10'd1000, 10'd3, 1'b0);
        queue_visit(8'd0, 1'b0);
        queue_visit(8'd1, 1'b1);
        queue_visit(8'd2, 1'b0);
        queue_visit(8'd1, 1'b1);
        gen_traffic(650);
        wait_sent();

        idle_pct = 59;
        gen_traffic(650);
        wait_sent();

        // No idling: one tour long enough to clamp the sum, then more traffic
        idle_pct = 0;
        queue_xfer(CMD_LOAD, 8'd10, '0, '0, 1'b0);
        queue_xfer(CMD_LOAD, 8'd11, '1, '1, 1'b0);
        for (int i = 0; i < SAT_VISITS; i++)
            queue_visit((i % 2 == 0) ? 8'd10 : 8'd11, i == SAT_VISITS - 1);
        gen_traffic(300);
        wait_sent();

        // Drain outstanding results, then allow the block to settle
        while (expected_len.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_len.size() != 0)
            report_fail($sformatf("%0d expected results never arrived", expected_len.size()));

        $display("covered %0d transfers and %0d tour results (%0d clamped)",
                 n_xfers, n_tours, n_saturated);
        $display("sender idle at 11%%, 59%% and 0%% of cycles; %0d failures", errors);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
